// File: hdl/shi_pkg.sv
// Shared types and constants for the serial host interface slave.
`timescale 1ns / 1ps

package shi_pkg;

    localparam int DATA_W = 24;
    localparam int CMD_W  = 2;
    localparam int SEL_W  = 3;

    // control/status layout
    localparam int CTL_W    = 14;   // writable control bits [13:0]
    localparam int BIT_EN   = 0;
    localparam int BIT_TIE  = 11;
    localparam int BIT_RIE  = 12;   // receive irq mode [13:12]
    localparam int BIT_TUE  = 14;
    localparam int BIT_TDE  = 15;
    localparam int BIT_RNE  = 17;
    localparam int BIT_RFF  = 19;
    localparam int BIT_ROE  = 20;
    localparam int BIT_BER  = 21;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_EXCHANGE = 2'd2
    } t_cmd;

    typedef enum logic [SEL_W-1:0] {
        SEL_CLOCK    = 3'd0,
        SEL_STATUS   = 3'd1,
        SEL_ADDRESS  = 3'd2,
        SEL_TRANSMIT = 3'd3,
        SEL_RECEIVE  = 3'd4
    } t_sel;

    typedef enum logic [1:0] {
        RIE_OFF       = 2'd0,
        RIE_NOT_EMPTY = 2'd1,
        RIE_FULL      = 2'd2,
        RIE_ALT       = 2'd3
    } t_rie;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_fifo_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] shifted_out;
        logic              word_sent;
        logic              irq_transmit_data;
        logic              irq_transmit_underrun;
        logic              irq_receive_not_empty;
        logic              irq_receive_full;
        logic              irq_receive_overrun;
    } t_result;

endpackage

// File: hdl/shi_fifo.sv
// Receive FIFO: shift-down register file with a fill count.
`timescale 1ns / 1ps

module shi_fifo
    import shi_pkg::*;
#(
    parameter int FIFO_DEPTH = 10,
    parameter int CNT_W      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fifo_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_data,
    output logic [CNT_W-1:0]  o_count,
    output logic [DATA_W-1:0] o_head
);

    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [FIFO_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [IDX_W-1:0]  w_wr_idx;

    assign w_wr_idx = r_count[IDX_W-1:0];

    // push only below full, pop only when not empty (caller guarantees)
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < FIFO_DEPTH; g++) begin : g_entry
        localparam logic [IDX_W-1:0] K = IDX_W'(g);
        if (g < FIFO_DEPTH - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_cmd.push && w_wr_idx == K) begin
                    r_mem[g] <= i_data;
                end else if (i_cmd.pop) begin
                    r_mem[g] <= r_mem[g+1];
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_cmd.push && w_wr_idx == K) begin
                    r_mem[g] <= i_data;
                end
            end
        end
    end

    assign o_count = r_count;
    assign o_head  = r_mem[0];

endmodule

// File: hdl/shi_ctrl.sv
// Register file, status flags and per-item command execution.
`timescale 1ns / 1ps

module shi_ctrl
    import shi_pkg::*;
#(
    parameter int FIFO_DEPTH = 10,
    parameter int CNT_W      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [SEL_W-1:0]  i_reg_select,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_head,
    output t_fifo_cmd         o_fifo,
    output t_result           o_result
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

    logic [DATA_W-1:0] r_clock, n_clock;
    logic [DATA_W-1:0] r_addr, n_addr;
    logic [DATA_W-1:0] r_tx, n_tx;
    logic [CTL_W-1:0]  r_ctl, n_ctl;
    logic              r_tue, n_tue;
    logic              r_tde, n_tde;
    logic              r_roe, n_roe;

    logic              w_rne;
    logic              w_rff;
    logic [DATA_W-1:0] w_status;
    logic [1:0]        w_mode;
    logic              w_off;
    logic [CNT_W-1:0]  w_cnt_after;

    assign w_rne = (i_count != '0);
    assign w_rff = (i_count >= DEPTH_C);
    assign w_mode = r_ctl[BIT_RIE +: 2];

    always_comb begin
        w_status = '0;
        w_status[CTL_W-1:0] = r_ctl;
        w_status[BIT_TUE]   = r_tue;
        w_status[BIT_TDE]   = r_tde;
        w_status[BIT_RNE]   = w_rne;
        w_status[BIT_RFF]   = w_rff;
        w_status[BIT_ROE]   = r_roe;
        w_status[BIT_BER]   = 1'b0;   // no bus error source in this block
    end

    always_comb begin
        n_clock     = r_clock;
        n_addr      = r_addr;
        n_tx        = r_tx;
        n_ctl       = r_ctl;
        n_tue       = r_tue;
        n_tde       = r_tde;
        n_roe       = r_roe;
        o_fifo      = '0;
        o_result    = '0;
        w_off       = 1'b0;
        w_cnt_after = i_count;
        if (i_fire) begin
            case (t_cmd'(i_command))
                CMD_READ: begin
                    case (t_sel'(i_reg_select))
                        SEL_CLOCK:   o_result.read_data = r_clock;
                        SEL_STATUS:  o_result.read_data = w_status;
                        SEL_ADDRESS: o_result.read_data = r_addr;
                        SEL_RECEIVE: begin
                            if (w_rne) begin
                                o_result.read_data = i_head;
                                o_fifo.pop         = 1'b1;
                                n_roe              = 1'b0;
                            end
                        end
                        default: o_result.read_data = '0;
                    endcase
                end
                CMD_WRITE: begin
                    case (t_sel'(i_reg_select))
                        SEL_CLOCK:   n_clock = i_write_data;
                        SEL_ADDRESS: n_addr  = i_write_data;
                        SEL_STATUS: begin
                            n_ctl = i_write_data[CTL_W-1:0];
                            w_off = r_ctl[BIT_EN] && !i_write_data[BIT_EN];
                            if (w_off) begin
                                o_fifo.clear = 1'b1;
                                w_cnt_after  = '0;
                                n_tx         = '0;
                                n_tue        = 1'b0;
                                n_roe        = 1'b0;
                                n_tde        = 1'b1;
                            end
                            case (t_rie'(i_write_data[BIT_RIE +: 2]))
                                RIE_FULL:
                                    o_result.irq_receive_full = (w_cnt_after >= DEPTH_C);
                                RIE_NOT_EMPTY, RIE_ALT:
                                    o_result.irq_receive_not_empty = (w_cnt_after != '0);
                                default: ;
                            endcase
                        end
                        SEL_TRANSMIT: begin
                            n_tx  = i_write_data;
                            n_tde = 1'b0;
                            n_tue = 1'b0;
                        end
                        default: ;
                    endcase
                end
                CMD_EXCHANGE: begin
                    if (r_ctl[BIT_EN]) begin
                        o_result.shifted_out = r_tx;
                        if (r_tde) begin
                            // underrun: stale word goes out again
                            n_tue = 1'b1;
                            o_result.irq_transmit_underrun = r_ctl[BIT_TIE];
                        end else begin
                            n_tde = 1'b1;
                            o_result.word_sent         = 1'b1;
                            o_result.irq_transmit_data = r_ctl[BIT_TIE];
                        end
                        if (w_rff) begin
                            n_roe = 1'b1;
                            o_result.irq_receive_overrun = (w_mode != RIE_OFF);
                        end else begin
                            o_fifo.push = 1'b1;
                            w_cnt_after = i_count + CNT_W'(1);
                            case (t_rie'(w_mode))
                                RIE_FULL:
                                    o_result.irq_receive_full = (w_cnt_after >= DEPTH_C);
                                RIE_NOT_EMPTY, RIE_ALT:
                                    o_result.irq_receive_not_empty = 1'b1;
                                default: ;
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            r_addr  <= '0;
            r_tx    <= '0;
            r_ctl   <= '0;
            r_tue   <= 1'b0;
            r_tde   <= 1'b0;
            r_roe   <= 1'b0;
        end else begin
            r_clock <= n_clock;
            r_addr  <= n_addr;
            r_tx    <= n_tx;
            r_ctl   <= n_ctl;
            r_tue   <= n_tue;
            r_tde   <= n_tde;
            r_roe   <= n_roe;
        end
    end

endmodule

// File: hdl/serial_host_interface_slave.sv
// Top level of the serial host interface slave: item pipeline and submodules.
`timescale 1ns / 1ps

// Serial host interface slave. Each input item is a bus read, a bus write
// or one 24-bit word exchange with the serial peer; each item yields exactly
// one result item with the read value, the word shifted out and the
// interrupt requests it raised. Throughput is one item per clock while the
// result side does not stall. An item is captured in the input register,
// executed against the register file and receive FIFO once the output
// register can take its result, and its result lands in the output register.
// The state update between those registers is combinational and sets the
// rate. Both sides use valid/stall: a stalled result holds the output
// register, and the input side keeps accepting as long as the result can
// move on. The receive FIFO holds FIFO_DEPTH words and needs no clearing
// pass after reset; its fill count alone defines which entries are live.
// Clearing the enable bit empties the FIFO and resets the transmit side.

module serial_host_interface_slave
    import shi_pkg::*;
#(
    parameter int FIFO_DEPTH = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [SEL_W-1:0]  i_reg_select,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [DATA_W-1:0] i_peer_word,
    // result item channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic [DATA_W-1:0] o_shifted_out,
    output logic              o_word_sent,
    output logic              o_irq_transmit_data,
    output logic              o_irq_transmit_underrun,
    output logic              o_irq_receive_not_empty,
    output logic              o_irq_receive_full,
    output logic              o_irq_receive_overrun
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // input register
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_in_cmd;
    logic [SEL_W-1:0]  r_in_sel;
    logic [DATA_W-1:0] r_in_wdata;
    logic [DATA_W-1:0] r_in_peer;

    // output register
    logic              r_out_valid;
    t_result           r_out;

    logic              w_out_ready;
    logic              w_fire;
    logic              w_in_take;
    t_result           w_result;
    t_fifo_cmd         w_fifo_cmd;
    logic [CNT_W-1:0]  w_count;
    logic [DATA_W-1:0] w_head;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_ready;   // item executes now
    assign o_in_stall  = r_in_valid && !w_out_ready;
    assign w_in_take   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_cmd   <= i_command;
            r_in_sel   <= i_reg_select;
            r_in_wdata <= i_write_data;
            r_in_peer  <= i_peer_word;
        end
    end

    shi_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_command    (r_in_cmd),
        .i_reg_select (r_in_sel),
        .i_write_data (r_in_wdata),
        .i_count      (w_count),
        .i_head       (w_head),
        .o_fifo       (w_fifo_cmd),
        .o_result     (w_result)
    );

    shi_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CNT_W      (CNT_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_fifo_cmd),
        .i_data  (r_in_peer),
        .o_count (w_count),
        .o_head  (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_read_data             = r_out.read_data;
    assign o_shifted_out           = r_out.shifted_out;
    assign o_word_sent             = r_out.word_sent;
    assign o_irq_transmit_data     = r_out.irq_transmit_data;
    assign o_irq_transmit_underrun = r_out.irq_transmit_underrun;
    assign o_irq_receive_not_empty = r_out.irq_receive_not_empty;
    assign o_irq_receive_full      = r_out.irq_receive_full;
    assign o_irq_receive_overrun   = r_out.irq_receive_overrun;

endmodule

// File: tb/serial_host_interface_slave_tb.sv
// Self-checking testbench for the serial host interface slave.
`timescale 1ns / 1ps

// A directed table covers reset values, register extremes, write-only and
// unused selects, the unused command, disabled exchange, underrun and the
// disable clear. Then come random sequences: exchange bursts that fill and
// overrun the receive FIFO, receive drains, control writes, register
// round trips and some noise. Every accepted item runs through a local
// predictor. Its result is queued and compared, field by field, with the
// block's results in order. Both channels idle at random. A long receiver
// hold-off backs the block up, and the sender also pauses until empty.

module serial_host_interface_slave_tb;
    import shi_pkg::*;

    localparam int RX_DEPTH    = 10;
    localparam int RANDOM_GOAL = 900;
    localparam int HOLDOFF_LEN = 80;
    localparam int CYCLE_LIMIT = 200_000;

    // codes the package enums leave out
    localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;
    localparam logic [SEL_W-1:0] SEL_FIRST_SPARE = 3'd5;
    localparam logic [SEL_W-1:0] SEL_LAST_SPARE  = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_command;
    logic [SEL_W-1:0]  i_reg_select;
    logic [DATA_W-1:0] i_write_data;
    logic [DATA_W-1:0] i_peer_word;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [DATA_W-1:0] o_read_data;
    logic [DATA_W-1:0] o_shifted_out;
    logic              o_word_sent;
    logic              o_irq_transmit_data;
    logic              o_irq_transmit_underrun;
    logic              o_irq_receive_not_empty;
    logic              o_irq_receive_full;
    logic              o_irq_receive_overrun;

    serial_host_interface_slave #(
        .FIFO_DEPTH(RX_DEPTH)
    ) i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_command              (i_command),
        .i_reg_select           (i_reg_select),
        .i_write_data           (i_write_data),
        .i_peer_word            (i_peer_word),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_read_data            (o_read_data),
        .o_shifted_out          (o_shifted_out),
        .o_word_sent            (o_word_sent),
        .o_irq_transmit_data    (o_irq_transmit_data),
        .o_irq_transmit_underrun(o_irq_transmit_underrun),
        .o_irq_receive_not_empty(o_irq_receive_not_empty),
        .o_irq_receive_full     (o_irq_receive_full),
        .o_irq_receive_overrun  (o_irq_receive_overrun)
    );

    // one row of the directed table; fixed rows carry a typed-in read value
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [SEL_W-1:0]  sel;
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] peer;
        bit                fixed;
        t_result           want;
    } t_stim_row;

    t_stim_row stim_table[$];
    t_result   expected_results[$];

    // shadow copy of the block state
    logic [DATA_W-1:0] mdl_clock   = '0;
    logic [DATA_W-1:0] mdl_status  = '0;
    logic [DATA_W-1:0] mdl_address = '0;
    logic [DATA_W-1:0] mdl_tx      = '0;
    logic [DATA_W-1:0] rx_words[$];

    int mismatches   = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int live_items   = 0;
    int n_overrun    = 0;
    int n_underrun   = 0;
    int n_full       = 0;
    int n_not_empty  = 0;
    int cycle_count  = 0;

    // traffic shaping, written by the stimulus process only
    bit calm          = 1'b0;
    int holdoff_reqs  = 0;
    // owned by the receiver process
    int holdoff_seen  = 0;
    int holdoff_left  = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void refresh_rx_flags();
        mdl_status[BIT_RNE] = (rx_words.size() != 0);
        mdl_status[BIT_RFF] = (rx_words.size() >= RX_DEPTH);
    endfunction

    // receive irq by mode: not empty for modes 1 and 3, full for mode 2
    function automatic void raise_rx_irq(inout t_result r);
        case (t_rie'(mdl_status[BIT_RIE +: 2]))
            RIE_OFF: ;
            RIE_FULL: begin
                if (mdl_status[BIT_RFF]) begin
                    r.irq_receive_full = 1'b1;
                    n_full++;
                end
            end
            default: begin
                if (mdl_status[BIT_RNE]) begin
                    r.irq_receive_not_empty = 1'b1;
                    n_not_empty++;
                end
            end
        endcase
    endfunction

    function automatic t_result predict_result(
        input logic [CMD_W-1:0]  cmd,
        input logic [SEL_W-1:0]  sel,
        input logic [DATA_W-1:0] wdata,
        input logic [DATA_W-1:0] peer
    );
        t_result r;
        logic    was_on;
        r = '0;
        case (cmd)
            CMD_READ: begin
                case (sel)
                    SEL_CLOCK:   r.read_data = mdl_clock;
                    SEL_STATUS:  r.read_data = mdl_status;
                    SEL_ADDRESS: r.read_data = mdl_address;
                    SEL_RECEIVE: begin
                        // pop from an empty FIFO reads zero and changes nothing
                        if (rx_words.size() != 0) begin
                            r.read_data = rx_words.pop_front();
                            refresh_rx_flags();
                            mdl_status[BIT_ROE] = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_WRITE: begin
                case (sel)
                    SEL_CLOCK:   mdl_clock = wdata;
                    SEL_ADDRESS: mdl_address = wdata;
                    SEL_STATUS: begin
                        was_on = mdl_status[BIT_EN];
                        mdl_status[CTL_W-1:0] = wdata[CTL_W-1:0];
                        // falling enable flushes the receive and transmit sides
                        if (was_on && !mdl_status[BIT_EN]) begin
                            rx_words.delete();
                            mdl_tx = '0;
                            mdl_status[BIT_TUE] = 1'b0;
                            mdl_status[BIT_ROE] = 1'b0;
                            mdl_status[BIT_BER] = 1'b0;
                            mdl_status[BIT_TDE] = 1'b1;
                        end
                        refresh_rx_flags();
                        raise_rx_irq(r);
                    end
                    SEL_TRANSMIT: begin
                        mdl_tx = wdata;
                        mdl_status[BIT_TDE] = 1'b0;
                        mdl_status[BIT_TUE] = 1'b0;
                    end
                    default: ;
                endcase
            end
            CMD_EXCHANGE: begin
                if (mdl_status[BIT_EN]) begin
                    r.shifted_out = mdl_tx;
                    if (mdl_status[BIT_TDE]) begin
                        // nothing refilled: old word repeats
                        mdl_status[BIT_TUE] = 1'b1;
                        r.irq_transmit_underrun = mdl_status[BIT_TIE];
                        if (mdl_status[BIT_TIE]) n_underrun++;
                    end else begin
                        mdl_status[BIT_TDE] = 1'b1;
                        r.word_sent = 1'b1;
                        r.irq_transmit_data = mdl_status[BIT_TIE];
                    end
                    if (rx_words.size() >= RX_DEPTH) begin
                        mdl_status[BIT_ROE] = 1'b1;
                        r.irq_receive_overrun = (mdl_status[BIT_RIE +: 2] != RIE_OFF);
                        if (r.irq_receive_overrun) n_overrun++;
                    end else begin
                        rx_words.push_back(peer);
                        refresh_rx_flags();
                        raise_rx_irq(r);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, receiver
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side stall: random idling, or a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (holdoff_left != 0) begin
            i_out_stall  <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_seen != holdoff_reqs) begin
            i_out_stall  <= 1'b1;
            holdoff_seen <= holdoff_reqs;
            holdoff_left <= HOLDOFF_LEN - 1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 16);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_read_data, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_shifted_out !== want.shifted_out)
                    report_mismatch("shifted_out", o_shifted_out, want.shifted_out);
                if (o_word_sent !== want.word_sent)
                    report_mismatch("word_sent", DATA_W'(o_word_sent),
                                    DATA_W'(want.word_sent));
                if (o_irq_transmit_data !== want.irq_transmit_data)
                    report_mismatch("irq_transmit_data", DATA_W'(o_irq_transmit_data),
                                    DATA_W'(want.irq_transmit_data));
                if (o_irq_transmit_underrun !== want.irq_transmit_underrun)
                    report_mismatch("irq_transmit_underrun",
                                    DATA_W'(o_irq_transmit_underrun),
                                    DATA_W'(want.irq_transmit_underrun));
                if (o_irq_receive_not_empty !== want.irq_receive_not_empty)
                    report_mismatch("irq_receive_not_empty",
                                    DATA_W'(o_irq_receive_not_empty),
                                    DATA_W'(want.irq_receive_not_empty));
                if (o_irq_receive_full !== want.irq_receive_full)
                    report_mismatch("irq_receive_full", DATA_W'(o_irq_receive_full),
                                    DATA_W'(want.irq_receive_full));
                if (o_irq_receive_overrun !== want.irq_receive_overrun)
                    report_mismatch("irq_receive_overrun", DATA_W'(o_irq_receive_overrun),
                                    DATA_W'(want.irq_receive_overrun));
            end
            results_seen++;
        end
    end

    // Hard stop if the run hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] random_word();
        return DATA_W'($urandom());
    endfunction

    // random control word; upper status bits random too, they must be masked
    function automatic logic [DATA_W-1:0] random_ctl(input bit en);
        logic [DATA_W-1:0] v;
        v = random_word();
        v[BIT_EN] = en;
        return v;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                                    input logic [DATA_W-1:0] wdata,
                                    input logic [DATA_W-1:0] peer);
        t_stim_row row;
        row.cmd   = cmd;
        row.sel   = sel;
        row.wdata = wdata;
        row.peer  = peer;
        row.fixed = 1'b0;
        row.want  = '0;
        stim_table.push_back(row);
    endfunction

    // row whose whole result is zero except a read value known up front
    function automatic void add_fixed(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                                      input logic [DATA_W-1:0] wdata,
                                      input logic [DATA_W-1:0] peer,
                                      input logic [DATA_W-1:0] rdata);
        add_row(cmd, sel, wdata, peer);
        stim_table[$].fixed = 1'b1;
        stim_table[$].want.read_data = rdata;
    endfunction

    // Offer one item, hold it until accepted, then record its expected result.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                             input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] peer,
                             input bit fixed, input t_result want);
        t_result predicted;
        bit      ignored;
        if (!calm && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_reg_select <= sel;
        i_write_data <= wdata;
        i_peer_word  <= peer;
        do @(posedge i_clk); while (o_in_stall);
        ignored = (cmd == CMD_UNUSED) || (cmd == CMD_WRITE && sel >= SEL_RECEIVE)
                  || (cmd == CMD_EXCHANGE && !mdl_status[BIT_EN]);
        if (!ignored) live_items++;
        items_sent++;
        predicted = predict_result(cmd, sel, wdata, peer);
        expected_results.push_back(fixed ? want : predicted);
    endtask

    // Sender pause: drop valid and let every pending result come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic send_random(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel);
        send_item(cmd, sel, random_word(), random_word(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int dir_live;
        int rnd_live;
        int pick;
        int n;
        bit holdoff_done;
        bit pause_done;
        logic [DATA_W-1:0] ctl_on;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_READ;
        i_reg_select = SEL_CLOCK;
        i_write_data = '0;
        i_peer_word  = '0;

        holdoff_done = 1'b0;
        pause_done   = 1'b0;
        // enable, transmit irq on, receive mode not-empty, junk above bit 13
        ctl_on = 24'hFFC000 | DATA_W'(1 << BIT_EN) | DATA_W'(1 << BIT_TIE)
                 | (DATA_W'(RIE_NOT_EMPTY) << BIT_RIE);

        // reset values, unused and write-only selects, unused command, disabled block
        add_fixed(CMD_READ, SEL_CLOCK, 24'hFFFFFF, 24'hFFFFFF, '0);
        add_fixed(CMD_READ, SEL_STATUS, '0, '0, '0);
        add_fixed(CMD_READ, SEL_ADDRESS, '0, '0, '0);
        add_fixed(CMD_READ, SEL_TRANSMIT, '0, '0, '0);
        add_fixed(CMD_READ, SEL_RECEIVE, '0, '0, '0);
        add_fixed(CMD_READ, SEL_LAST_SPARE, '0, '0, '0);
        add_fixed(CMD_EXCHANGE, SEL_CLOCK, '0, 24'hFFFFFF, '0);
        add_fixed(CMD_UNUSED, SEL_STATUS, 24'hFFFFFF, 24'hFFFFFF, '0);
        // register extremes, writes to read-only and unused selects
        add_fixed(CMD_WRITE, SEL_CLOCK, 24'hFFFFFF, '0, '0);
        add_fixed(CMD_READ, SEL_CLOCK, '0, '0, 24'hFFFFFF);
        add_fixed(CMD_WRITE, SEL_ADDRESS, 24'hFFFFFF, '0, '0);
        add_fixed(CMD_READ, SEL_ADDRESS, '0, '0, 24'hFFFFFF);
        add_fixed(CMD_WRITE, SEL_RECEIVE, 24'hFFFFFF, '0, '0);
        add_fixed(CMD_WRITE, SEL_FIRST_SPARE, 24'hFFFFFF, '0, '0);
        // enable; first exchange delivers the reset transmit word, second underruns
        add_row(CMD_WRITE, SEL_STATUS, ctl_on, '0);
        add_row(CMD_EXCHANGE, SEL_CLOCK, '0, 24'hFFFFFF);
        add_row(CMD_EXCHANGE, SEL_CLOCK, '0, 24'h000000);
        add_row(CMD_WRITE, SEL_TRANSMIT, 24'hA5A5A5, '0);
        add_row(CMD_EXCHANGE, SEL_CLOCK, '0, 24'h5A5A5A);
        add_row(CMD_READ, SEL_STATUS, '0, '0);
        add_row(CMD_READ, SEL_RECEIVE, '0, '0);
        // disable clears the status and the receive FIFO but leaves transmit empty set
        add_row(CMD_WRITE, SEL_STATUS, '0, '0);
        add_fixed(CMD_READ, SEL_STATUS, '0, '0, DATA_W'(1 << BIT_TDE));
        // mode 3 behaves as mode 1
        add_row(CMD_WRITE, SEL_STATUS,
                DATA_W'(1 << BIT_EN) | (DATA_W'(RIE_ALT) << BIT_RIE), '0);
        add_row(CMD_EXCHANGE, SEL_CLOCK, '0, 24'hFFFFFF);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k])
            send_item(stim_table[k].cmd, stim_table[k].sel, stim_table[k].wdata,
                      stim_table[k].peer, stim_table[k].fixed, stim_table[k].want);
        drain_results();
        dir_live = live_items;

        rnd_live = 0;
        while (rnd_live < RANDOM_GOAL) begin
            // receiver backs off long enough to fill the pipe
            if (!holdoff_done && rnd_live >= 250) begin
                holdoff_reqs <= holdoff_reqs + 1;
                holdoff_done = 1'b1;
            end
            // stretch with no idling on either side
            if (rnd_live >= 400 && rnd_live < 550 && !calm)
                calm <= 1'b1;
            else if (rnd_live >= 550 && calm)
                calm <= 1'b0;
            if (!pause_done && rnd_live >= 650) begin
                drain_results();
                pause_done = 1'b1;
            end

            pick = $urandom_range(99);
            if (pick < 30) begin
                // exchange burst, at times long enough to fill and overrun the FIFO
                if (!mdl_status[BIT_EN] && $urandom_range(9) < 8)
                    send_item(CMD_WRITE, SEL_STATUS, random_ctl(1'b1), random_word(),
                              1'b0, '0);
                n = $urandom_range(1, RX_DEPTH + 4);
                repeat (n) begin
                    if ($urandom_range(9) < 4)
                        send_random(CMD_WRITE, SEL_TRANSMIT);
                    send_random(CMD_EXCHANGE, SEL_W'($urandom_range(7)));
                end
            end else if (pick < 50) begin
                // receive drain, sometimes past empty
                n = $urandom_range(1, RX_DEPTH + 2);
                repeat (n) send_random(CMD_READ, SEL_RECEIVE);
            end else if (pick < 68) begin
                send_item(CMD_WRITE, SEL_STATUS, random_ctl($urandom_range(9) < 9),
                          random_word(), 1'b0, '0);
                send_random(CMD_READ, SEL_STATUS);
            end else if (pick < 80) begin
                // register round trip
                pick = $urandom_range(2);
                if (pick == 0) begin
                    send_random(CMD_WRITE, SEL_CLOCK);
                    send_random(CMD_READ, SEL_CLOCK);
                end else if (pick == 1) begin
                    send_random(CMD_WRITE, SEL_ADDRESS);
                    send_random(CMD_READ, SEL_ADDRESS);
                end else begin
                    send_random(CMD_WRITE, SEL_TRANSMIT);
                    send_random(CMD_READ, SEL_TRANSMIT);
                end
            end else if (pick < 90) begin
                // disable and re-enable
                send_item(CMD_WRITE, SEL_STATUS, random_ctl(1'b0), random_word(), 1'b0, '0);
                send_random(CMD_READ, SEL_STATUS);
                send_item(CMD_WRITE, SEL_STATUS, random_ctl(1'b1), random_word(), 1'b0, '0);
            end else begin
                // noise over the whole field space
                send_random(CMD_W'($urandom_range(3)), SEL_W'($urandom_range(7)));
            end
            rnd_live = live_items - dir_live;
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d items (%0d from the directed table), %0d results checked.",
                 items_sent, stim_table.size(), results_seen);
        $display("Irqs raised: %0d overrun, %0d underrun, %0d full, %0d not empty.",
                 n_overrun, n_underrun, n_full, n_not_empty);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/shi_pkg.sv
hdl/shi_fifo.sv
hdl/shi_ctrl.sv
hdl/serial_host_interface_slave.sv
tb/serial_host_interface_slave_tb.sv
